@@ rtl/core/fdt_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// fdt_tok_pkg
// shared types and constants for the device-tree structure block tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package fdt_tok_pkg;

   localparam int WORD_W   = 32;
   localparam int DEPTH_W  = 6;
   localparam int EVENT_W  = 3;
   localparam int DWL_W    = 31;                    // ceil(2^32-1 / 4) needs 31 bits

   localparam logic [DEPTH_W-1:0] MAX_DEPTH = 6'd63;

   // event queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // structure block tokens
   localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'h0000_0001;
   localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'h0000_0002;
   localparam logic [WORD_W-1:0] TOK_PROP       = 32'h0000_0003;
   localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
   localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

   localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

   // event codes
   localparam logic [EVENT_W-1:0] EV_BEGIN_NODE = 3'd0;
   localparam logic [EVENT_W-1:0] EV_NAME       = 3'd1;
   localparam logic [EVENT_W-1:0] EV_END_NODE   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_PROP       = 3'd3;
   localparam logic [EVENT_W-1:0] EV_PROP_DATA  = 3'd4;
   localparam logic [EVENT_W-1:0] EV_NOP        = 3'd5;
   localparam logic [EVENT_W-1:0] EV_END        = 3'd6;
   localparam logic [EVENT_W-1:0] EV_BAD_TOKEN  = 3'd7;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [WORD_W-1:0]  value;
      logic [WORD_W-1:0]  prop_length;
      logic [WORD_W-1:0]  name_offset;
      logic               last;
      logic [DEPTH_W-1:0] depth;
   } fdt_tok_event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fdt_tok_qstat_type;

endpackage

`default_nettype wire

@@ rtl/core/fdt_tok_front.sv @@
// ----------------------------------------------------------------------------
// fdt_tok_front
// request side: token classification, phase tracking, depth and byte count
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_tok_front
   import fdt_tok_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [WORD_W-1:0]     csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_W-1:0]     req_word,
   input  wire logic                  req_first,
   input  wire fdt_tok_qstat_type     qstat,
   output logic                       push,
   output fdt_tok_event_type          push_event
);

   localparam logic [2:0] PH_TOKEN = 3'd0;
   localparam logic [2:0] PH_NAME  = 3'd1;
   localparam logic [2:0] PH_PLEN  = 3'd2;
   localparam logic [2:0] PH_POFF  = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_STOP  = 3'd5;

   logic [2:0]         phase_ff,  phase_in,  phase_eff;
   logic [WORD_W-1:0]  bytes_ff,  bytes_in,  bytes_eff;
   logic [DEPTH_W-1:0] depth_ff,  depth_in,  depth_eff;
   logic [DWL_W-1:0]   dwl_ff,    dwl_in,    dwl_eff;
   logic [WORD_W-1:0]  held_ff,   held_in,   held_eff;
   logic [WORD_W-1:0]  limit_ff,  limit_in;

   logic [WORD_W:0]    bytes_sum;
   logic [WORD_W-1:0]  bytes_inc;
   logic [WORD_W:0]    words_sum;
   logic [DWL_W-1:0]   dwl_dec;
   logic               zero_byte;
   logic               take;

   assign req_ready = ~qstat.full;
   assign take      = req_valid & req_ready;

   // first word of a block restarts the parse
   assign phase_eff = req_first ? PH_TOKEN : phase_ff;
   assign bytes_eff = req_first ? '0 : bytes_ff;
   assign depth_eff = req_first ? '0 : depth_ff;
   assign dwl_eff   = req_first ? '0 : dwl_ff;
   assign held_eff  = req_first ? '0 : held_ff;

   // byte count saturates at all ones
   assign bytes_sum = {1'b0, bytes_eff} + {1'b0, WORD_BYTES};
   assign bytes_inc = bytes_sum[WORD_W] ? '1 : bytes_sum[WORD_W-1:0];

   assign words_sum = {1'b0, held_eff} + (WORD_W+1)'(3);
   assign dwl_dec   = (dwl_eff != '0) ? dwl_eff - DWL_W'(1) : dwl_eff;

   assign zero_byte = (req_word[31:24] == 8'h00) || (req_word[23:16] == 8'h00) ||
                      (req_word[15:8]  == 8'h00) || (req_word[7:0]   == 8'h00);

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_comb begin
      phase_in   = phase_ff;
      bytes_in   = bytes_ff;
      depth_in   = depth_ff;
      dwl_in     = dwl_ff;
      held_in    = held_ff;
      push       = 1'b0;
      push_event = '0;
      if (take) begin
         phase_in = phase_eff;
         bytes_in = bytes_eff;
         depth_in = depth_eff;
         dwl_in   = dwl_eff;
         held_in  = held_eff;
         unique case (phase_eff)
            PH_TOKEN: begin
               if (bytes_eff >= limit_ff) begin
                  phase_in = PH_STOP;
               end else begin
                  bytes_in = bytes_inc;
                  push     = 1'b1;
                  unique case (req_word)
                     TOK_BEGIN_NODE: begin
                        if (depth_eff < MAX_DEPTH) depth_in = depth_eff + DEPTH_W'(1);
                        phase_in             = PH_NAME;
                        push_event.event_res = EV_BEGIN_NODE;
                     end
                     TOK_END_NODE: begin
                        if (depth_eff != '0) depth_in = depth_eff - DEPTH_W'(1);
                        push_event.event_res = EV_END_NODE;
                     end
                     TOK_PROP: begin
                        phase_in = PH_PLEN;
                        push     = 1'b0;
                     end
                     TOK_NOP: begin
                        push_event.event_res = EV_NOP;
                     end
                     TOK_END: begin
                        phase_in             = PH_STOP;
                        push_event.event_res = EV_END;
                     end
                     default: begin
                        phase_in             = PH_STOP;
                        push_event.event_res = EV_BAD_TOKEN;
                        push_event.value     = req_word;
                     end
                  endcase
               end
            end
            PH_NAME: begin
               bytes_in             = bytes_inc;
               push                 = 1'b1;
               push_event.event_res = EV_NAME;
               push_event.value     = req_word;
               push_event.last      = zero_byte;
               if (zero_byte) phase_in = PH_TOKEN;
            end
            PH_PLEN: begin
               bytes_in = bytes_inc;
               held_in  = req_word;
               phase_in = PH_POFF;
            end
            PH_POFF: begin
               bytes_in               = bytes_inc;
               dwl_in                 = words_sum[WORD_W:2];
               phase_in               = (words_sum[WORD_W:2] == '0) ? PH_TOKEN : PH_DATA;
               push                   = 1'b1;
               push_event.event_res   = EV_PROP;
               push_event.prop_length = held_eff;
               push_event.name_offset = req_word;
            end
            PH_DATA: begin
               bytes_in             = bytes_inc;
               dwl_in               = dwl_dec;
               push                 = 1'b1;
               push_event.event_res = EV_PROP_DATA;
               push_event.value     = req_word;
               push_event.last      = (dwl_dec == '0);
               if (dwl_dec == '0) phase_in = PH_TOKEN;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end
      push_event.depth = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOKEN;
         bytes_ff <= '0;
         depth_ff <= '0;
         dwl_ff   <= '0;
         held_ff  <= '0;
         limit_ff <= '1;
      end else begin
         phase_ff <= phase_in;
         bytes_ff <= bytes_in;
         depth_ff <= depth_in;
         dwl_ff   <= dwl_in;
         held_ff  <= held_in;
         limit_ff <= limit_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fdt_tok_queue.sv @@
// ----------------------------------------------------------------------------
// fdt_tok_queue
// short event queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_tok_queue
   import fdt_tok_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fdt_tok_event_type  push_event,
   input  wire logic               pop,
   output fdt_tok_event_type       head_event,
   output fdt_tok_qstat_type       qstat
);

   fdt_tok_event_type  slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);

   assign do_push = push & ~qstat.full;
   assign do_pop  = pop & ~qstat.empty;

   assign head_event = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/fdt_tok_back.sv @@
// ----------------------------------------------------------------------------
// fdt_tok_back
// response side: output register fed from the event queue
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_tok_back
   import fdt_tok_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fdt_tok_qstat_type     qstat,
   input  wire fdt_tok_event_type     head_event,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [EVENT_W-1:0]         rsp_event_res,
   output logic [WORD_W-1:0]          rsp_value,
   output logic [WORD_W-1:0]          rsp_prop_length,
   output logic [WORD_W-1:0]          rsp_name_offset,
   output logic                       rsp_last,
   output logic [DEPTH_W-1:0]         rsp_depth
);

   logic              valid_ff, valid_in;
   fdt_tok_event_type out_ff;

   // refill whenever the register is empty or being drained
   assign pop      = ~qstat.empty & (~valid_ff | rsp_ready);
   assign valid_in = pop | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) out_ff <= head_event;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_event_res   = out_ff.event_res;
   assign rsp_value       = out_ff.value;
   assign rsp_prop_length = out_ff.prop_length;
   assign rsp_name_offset = out_ff.name_offset;
   assign rsp_last        = out_ff.last;
   assign rsp_depth       = out_ff.depth;

endmodule

`default_nettype wire

@@ rtl/core/fdt_struct_block_tokenizer.sv @@
// ----------------------------------------------------------------------------
// fdt_struct_block_tokenizer
// flattened device tree structure block tokenizer; while the event queue has room, one word per cycle
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid/req_ready): one big-endian 32-bit word of the
//   structure block per request; req_first marks the first word of a block
//   and restarts the parse (depth, byte count and phase cleared)
//   response channel (rsp_valid/rsp_ready): zero or one event per request,
//   in request order; words such as the property token and the length word
//   and anything after the stop give no event
//   csr_wr_en/csr_wr_data: byte limit, write only while idle
// timing
//   an event is written into the queue at the edge that accepts its
//   request and moved into the output register, which drives rsp_*,
//   once that register is empty or being drained
//   throughput is one request per cycle, set by the phase update in the
//   front that handles each word as it is accepted; req_ready only drops
//   when the 4-entry event queue is full
// reset
//   synchronous; parse state cleared, byte limit set to all ones, queue and
//   output register emptied
// stall
//   a held response stays in the output register, the queue fills behind it,
//   then req_ready goes low until the receiver drains
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_struct_block_tokenizer
   import fdt_tok_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [WORD_W-1:0]     csr_wr_data,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [WORD_W-1:0]     req_word,
   input  wire logic                  req_first,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [EVENT_W-1:0]         rsp_event_res,
   output logic [WORD_W-1:0]          rsp_value,
   output logic [WORD_W-1:0]          rsp_prop_length,
   output logic [WORD_W-1:0]          rsp_name_offset,
   output logic                       rsp_last,
   output logic [DEPTH_W-1:0]         rsp_depth
);

   fdt_tok_qstat_type qstat;
   fdt_tok_event_type push_event;
   fdt_tok_event_type head_event;
   logic              push;
   logic              pop;

   // front: classifies each word and updates the parse state
   fdt_tok_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .req_first   (req_first),
      .qstat       (qstat),
      .push        (push),
      .push_event  (push_event)
   );

   // decouples request acceptance from response backpressure
   fdt_tok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_event (head_event),
      .qstat      (qstat)
   );

   // back: output register toward the receiver
   fdt_tok_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .head_event      (head_event),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_value       (rsp_value),
      .rsp_prop_length (rsp_prop_length),
      .rsp_name_offset (rsp_name_offset),
      .rsp_last        (rsp_last),
      .rsp_depth       (rsp_depth)
   );

endmodule

`default_nettype wire

@@ rtl/core/fdt_tok_checker.sv @@
// ----------------------------------------------------------------------------
// fdt_tok_checker
// port-level checks on the tokenizer response channel
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_tok_checker
   import fdt_tok_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [EVENT_W-1:0]    rsp_event_res,
   input wire logic [WORD_W-1:0]     rsp_prop_length,
   input wire logic [WORD_W-1:0]     rsp_name_offset,
   input wire logic                  rsp_last
);

   // stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("response dropped or changed while stalled");

   // nothing left over from before reset
   a_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // last only marks name and property data words
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_event_res == EV_NAME) ||
                                (rsp_event_res == EV_PROP_DATA))
      else $error("last set on wrong event");

   // property fields are zero outside a property event
   a_prop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_PROP) |->
         (rsp_prop_length == '0) && (rsp_name_offset == '0))
      else $error("property fields set on non-property event");

endmodule

bind fdt_struct_block_tokenizer fdt_tok_checker u_fdt_tok_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_event_res   (rsp_event_res),
   .rsp_prop_length (rsp_prop_length),
   .rsp_name_offset (rsp_name_offset),
   .rsp_last        (rsp_last)
);

`default_nettype wire

@@ tb/sv/fdt_token_tracker_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_token_tracker_pkg
// expected-event tracker for the structure block tokenizer bench: follows the
// parse of every accepted word and checks each response against the oldest
// event it has worked out
// ----------------------------------------------------------------------------
package fdt_token_tracker_pkg;
   import fdt_tok_pkg::*;

   typedef enum logic [2:0] {
      PARSE_TOKEN,
      PARSE_NAME,
      PARSE_LENGTH,
      PARSE_OFFSET,
      PARSE_DATA,
      PARSE_STOPPED
   } parse_phase_type;

   class fdt_token_tracker;
      fdt_tok_event_type  expected_events[$];
      int unsigned        error_count;
      int unsigned        request_count;
      int unsigned        event_count;
      logic [WORD_W-1:0]  byte_limit;
      parse_phase_type    phase;
      logic [DWL_W-1:0]   words_left;
      logic [WORD_W-1:0]  len_held;
      logic [WORD_W-1:0]  bytes_taken;
      logic [DEPTH_W-1:0] nest;

      function new();
         byte_limit    = '1;
         error_count   = 0;
         request_count = 0;
         event_count   = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase       = PARSE_TOKEN;
         words_left  = '0;
         len_held    = '0;
         bytes_taken = '0;
         nest        = '0;
      endfunction

      // byte count saturates at all ones
      function void take_word();
         if (bytes_taken > (32'hFFFF_FFFF - WORD_BYTES))
            bytes_taken = '1;
         else
            bytes_taken = bytes_taken + WORD_BYTES;
      endfunction

      function bit holds_nul(logic [WORD_W-1:0] w);
         for (int i = 0; i < 4; i++)
            if (w[8*i +: 8] == 8'h00)
               return 1'b1;
         return 1'b0;
      endfunction

      // advance the parse by one accepted word, queue the event it gives
      function void note_request(logic [WORD_W-1:0] w, logic restart);
         fdt_tok_event_type ev;
         logic [WORD_W:0]   n_words;
         bit                produced;
         ev       = '0;
         produced = 1'b0;
         request_count++;
         if (restart)
            clear_parse();
         case (phase)
            PARSE_TOKEN: begin
               if (bytes_taken >= byte_limit) begin
                  phase = PARSE_STOPPED;
               end else begin
                  take_word();
                  produced = 1'b1;
                  case (w)
                     TOK_BEGIN_NODE: begin
                        if (nest < MAX_DEPTH)
                           nest = nest + 1'b1;
                        phase        = PARSE_NAME;
                        ev.event_res = EV_BEGIN_NODE;
                     end
                     TOK_END_NODE: begin
                        if (nest != '0)
                           nest = nest - 1'b1;
                        ev.event_res = EV_END_NODE;
                     end
                     TOK_PROP: begin
                        phase    = PARSE_LENGTH;
                        produced = 1'b0;
                     end
                     TOK_NOP: ev.event_res = EV_NOP;
                     TOK_END: begin
                        phase        = PARSE_STOPPED;
                        ev.event_res = EV_END;
                     end
                     default: begin
                        phase        = PARSE_STOPPED;
                        ev.event_res = EV_BAD_TOKEN;
                        ev.value     = w;
                     end
                  endcase
               end
            end
            PARSE_NAME: begin
               take_word();
               produced     = 1'b1;
               ev.event_res = EV_NAME;
               ev.value     = w;
               ev.last      = holds_nul(w);
               if (ev.last)
                  phase = PARSE_TOKEN;
            end
            PARSE_LENGTH: begin
               take_word();
               len_held = w;
               phase    = PARSE_OFFSET;
            end
            PARSE_OFFSET: begin
               take_word();
               n_words        = ({1'b0, len_held} + 33'd3) >> 2;
               words_left     = n_words[DWL_W-1:0];
               phase          = (words_left == '0) ? PARSE_TOKEN : PARSE_DATA;
               produced       = 1'b1;
               ev.event_res   = EV_PROP;
               ev.prop_length = len_held;
               ev.name_offset = w;
            end
            PARSE_DATA: begin
               take_word();
               if (words_left != '0)
                  words_left = words_left - 1'b1;
               produced     = 1'b1;
               ev.event_res = EV_PROP_DATA;
               ev.value     = w;
               ev.last      = (words_left == '0);
               if (ev.last)
                  phase = PARSE_TOKEN;
            end
            default: phase = PARSE_STOPPED;
         endcase
         if (produced) begin
            ev.depth = nest;
            expected_events.push_back(ev);
         end
      endfunction

      function void compare_field(string field, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            error_count++;
         end
      endfunction

      function void check_event(fdt_tok_event_type got);
         fdt_tok_event_type want;
         event_count++;
         if (expected_events.size() == 0) begin
            $error("event %0d with value %0h arrived with none pending",
                   got.event_res, got.value);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("value", want.value, got.value);
            compare_field("prop_length", want.prop_length, got.prop_length);
            compare_field("name_offset", want.name_offset, got.name_offset);
            compare_field("last", want.last, got.last);
            compare_field("depth", want.depth, got.depth);
         end
      endfunction
   endclass

endpackage

@@ tb/sv/tb_fdt_struct_block_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fdt_struct_block_tokenizer
// self-checking bench for the device-tree structure block tokenizer: drives
// directed and random structure blocks under several byte limits and stall
// patterns, and checks every event against a tracked parse
// ----------------------------------------------------------------------------
module tb_fdt_struct_block_tokenizer;
   import fdt_tok_pkg::*;
   import fdt_token_tracker_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;       // lets words with no event drain
   localparam int HOLD_CYCLES  = 400;     // long response hold-off
   localparam int QUIET_LIMIT  = 2000;    // well above hold-off plus pauses

   // one word of stimulus with its restart flag
   typedef struct packed {
      logic              first;
      logic [WORD_W-1:0] word;
   } stim_word_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [WORD_W-1:0]   csr_wr_data = '0;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [WORD_W-1:0]   req_word    = '0;
   logic                req_first   = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [EVENT_W-1:0]  rsp_event_res;
   logic [WORD_W-1:0]   rsp_value;
   logic [WORD_W-1:0]   rsp_prop_length;
   logic [WORD_W-1:0]   rsp_name_offset;
   logic                rsp_last;
   logic [DEPTH_W-1:0]  rsp_depth;

   fdt_token_tracker    tracker;
   stim_word_type       stim_words[$];
   logic                next_first;
   int                  send_idle_pct = 20;
   int                  recv_idle_pct = 79;
   bit                  hold_rsp      = 1'b0;
   int unsigned         block_count   = 0;
   int unsigned         quiet_cycles  = 0;
   logic [WORD_W-1:0]   mid_limit;

   always #6 clock = ~clock;

   fdt_struct_block_tokenizer uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_value       (rsp_value),
      .rsp_prop_length (rsp_prop_length),
      .rsp_name_offset (rsp_name_offset),
      .rsp_last        (rsp_last),
      .rsp_depth       (rsp_depth)
   );

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------

   // queue a word; the first word after a block start carries the restart
   function void put(logic [WORD_W-1:0] w);
      stim_words.push_back({next_first, w});
      next_first = 1'b0;
   endfunction

   // non-final name words have no zero byte, the final one has at least one
   function automatic logic [WORD_W-1:0] name_word(bit final_word);
      logic [WORD_W-1:0] w;
      int                nul_at;
      for (int i = 0; i < 4; i++) begin
         if (final_word)
            w[8*i +: 8] = 8'($urandom_range(0, 255));
         else
            w[8*i +: 8] = 8'($urandom_range(1, 255));
      end
      if (final_word) begin
         nul_at          = $urandom_range(0, 3);
         w[8*nul_at +: 8] = 8'h00;
      end
      return w;
   endfunction

   task automatic append_name();
      repeat ($urandom_range(0, 2)) put(name_word(1'b0));
      put(name_word(1'b1));
   endtask

   // property token, length, name offset and data; a huge length is cut
   // short and the caller starts a new block in the middle of the data
   task automatic append_property(output bit cut_short);
      logic [WORD_W-1:0] len;
      int                pick;
      int                n_data;
      pick      = $urandom_range(0, 9);
      cut_short = 1'b0;
      if (pick < 7)
         len = $urandom_range(0, 24);
      else if (pick < 9)
         len = $urandom_range(25, 64);
      else
         len = 32'hFFFF_FFFC + $urandom_range(0, 3);
      if (pick == 9) begin
         cut_short = 1'b1;
         n_data    = $urandom_range(0, 3);
      end else begin
         n_data = (len + 3) / 4;
      end
      put(TOK_PROP);
      put(len);
      put($urandom);
      repeat (n_data) put($urandom);
   endtask

   task automatic build_directed();
      block_count++;
      next_first = 1'b1;
      put(TOK_BEGIN_NODE);
      put(32'h6162_6364);               // name word without terminator
      put(32'h6566_0000);               // terminator in the low bytes
      put(TOK_PROP);
      put(32'd5);                       // five bytes: two data words
      put(32'h0000_0012);
      put(32'hDEAD_BEEF);
      put(32'h7700_0000);
      put(TOK_PROP);
      put(32'd0);                       // empty property, straight back to tokens
      put(32'hFFFF_FFFF);
      put(TOK_NOP);
      put(TOK_END_NODE);
      put(TOK_END_NODE);                // depth already zero, stays there
      put(TOK_END);
      put(TOK_BEGIN_NODE);              // ignored after the end token
      block_count++;
      next_first = 1'b1;
      put(32'hFFFF_FFFF);               // unknown token, all ones
      block_count++;
      next_first = 1'b1;
      put(32'h0000_0000);               // unknown token, all zeros
      block_count++;
      next_first = 1'b1;
      put(TOK_PROP);
      put(32'hFFFF_FFFF);               // largest length, data never finishes
      put(32'h0000_0000);
      put(32'h8000_0001);
      put(32'h1234_5678);               // next block restarts mid-data
   endtask

   task automatic build_random_block();
      int open_nodes;
      int steps;
      bit cut;
      block_count++;
      next_first = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
         // pure noise with random restarts
         put($urandom);
         repeat ($urandom_range(2, 6)) begin
            next_first = 1'($urandom_range(0, 1));
            put($urandom);
         end
      end else begin
         put(TOK_BEGIN_NODE);
         put(32'h0000_0000);            // root node has an empty name
         open_nodes = 1;
         cut        = 1'b0;
         steps      = $urandom_range(3, 12);
         for (int s = 0; s < steps && !cut; s++) begin
            case ($urandom_range(0, 19))
               0, 1, 19: put(TOK_NOP);
               2, 3, 4, 5, 6: begin
                  put(TOK_BEGIN_NODE);
                  append_name();
                  open_nodes++;
               end
               7, 8, 9, 10, 11: append_property(cut);
               12, 13, 14, 15: begin
                  if (open_nodes > 1) begin
                     put(TOK_END_NODE);
                     open_nodes--;
                  end else begin
                     put(TOK_NOP);
                  end
               end
               16: put($urandom);                      // stray word as token
               17: put($urandom_range(0, 15));         // near-miss token value
               default: cut = 1'b1;                    // block abandoned
            endcase
         end
         if (!cut) begin
            repeat (open_nodes) put(TOK_END_NODE);
            put(TOK_END);
            if ($urandom_range(0, 7) == 0)
               put($urandom);                          // trailing junk, ignored
         end
      end
   endtask

   // nesting well past the maximum, then closed past zero
   task automatic build_deep_block();
      block_count++;
      next_first = 1'b1;
      repeat (int'(MAX_DEPTH) + 3) begin
         put(TOK_BEGIN_NODE);
         put(32'h0000_0000);
      end
      repeat (int'(MAX_DEPTH) + 5) put(TOK_END_NODE);
      put(TOK_END);
   endtask

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // offer one request; returns at the falling edge after it is accepted
   task automatic send_word(logic [WORD_W-1:0] w, logic f);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      req_first <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(w, f);
      @(negedge clock);
   endtask

   task automatic send_all();
      stim_word_type item;
      while (stim_words.size() > 0) begin
         item = stim_words.pop_front();
         send_word(item.word, item.first);
      end
   endtask

   // wait for every expected event, then let words with no event drain
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called while the block is idle
   task automatic write_byte_limit(logic [WORD_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.byte_limit = limit;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // every accepted event goes to the tracker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_event({rsp_event_res, rsp_value, rsp_prop_length,
                              rsp_name_offset, rsp_last, rsp_depth});
   end

   // watchdog: too long with neither channel moving ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      tracker = new();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender mostly busy, receiver mostly stalled; no byte limit
      write_byte_limit(32'hFFFF_FFFF);
      build_directed();
      send_all();
      while (tracker.request_count < 180) begin
         build_random_block();
         send_all();
      end
      settle();

      // stall pattern swapped; byte limit at zero, one word, then mid-range
      send_idle_pct = 79;
      recv_idle_pct = 20;
      write_byte_limit(32'h0000_0000);
      repeat (4) begin
         build_random_block();
         send_all();
      end
      settle();
      write_byte_limit(WORD_BYTES);
      repeat (4) begin
         build_random_block();
         send_all();
      end
      settle();
      mid_limit = $urandom_range(8, 160);
      write_byte_limit(mid_limit);
      while (tracker.request_count < 300) begin
         build_random_block();
         send_all();
      end
      settle();

      // no idling; long response hold-off fills the block and stalls requests
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_byte_limit(32'hFFFF_FFFF);
      hold_rsp = 1'b1;
      build_deep_block();
      send_all();
      while (tracker.request_count < 560) begin
         build_random_block();
         send_all();
      end
      settle();

      $display("covered %0d requests and %0d events in %0d blocks, byte limits",
               tracker.request_count, tracker.event_count, block_count);
      $display("  all ones, 0, 4 and %0d, nesting saturated at both ends", mid_limit);
      if (tracker.error_count == 0 && tracker.expected_events.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/fdt_tok_pkg.sv
rtl/core/fdt_tok_front.sv
rtl/core/fdt_tok_queue.sv
rtl/core/fdt_tok_back.sv
rtl/core/fdt_struct_block_tokenizer.sv
rtl/core/fdt_tok_checker.sv
tb/sv/fdt_token_tracker_pkg.sv
tb/sv/tb_fdt_struct_block_tokenizer.sv
